### hw/rtl/pbf_pkg.sv
package pbf_pkg;

    // Table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int CMD_W         = 3;
    localparam int PID_W         = 32;
    localparam int KIND_W        = 2;
    localparam int ENTRY_COUNT_W = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;

    // Operation kind that is never relevant for a check
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Classified operation
    typedef enum logic [2:0] {
        OP_CHECK,
        OP_BLOCK,
        OP_UNBLOCK,
        OP_CLEAR,
        OP_INVALID
    } t_op;

    // Item as it travels from front to back
    typedef struct packed {
        t_op              op;
        logic             relevant;
        logic [PID_W-1:0] pid;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR
    } t_state;

endpackage

### hw/rtl/pbf_ram.sv
module pbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pbf_front.sv
module pbf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pbf_pkg::CMD_W-1:0]  i_command,
    input  logic [pbf_pkg::PID_W-1:0]  i_pid,
    input  logic [pbf_pkg::KIND_W-1:0] i_operation_kind,
    output logic                       o_busy,
    output logic                       o_valid,
    output pbf_pkg::t_item             o_item,
    input  logic                       i_pop
);

    import pbf_pkg::*;

    t_item      w_item;
    t_item      r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic       w_push;

    // Classify the incoming command
    always_comb begin
        w_item.pid      = i_pid;
        w_item.relevant = (i_operation_kind != KIND_OTHER);
        case (i_command)
            CMD_CHECK:   w_item.op = OP_CHECK;
            CMD_BLOCK:   w_item.op = OP_BLOCK;
            CMD_UNBLOCK: w_item.op = OP_UNBLOCK;
            CMD_CLEAR:   w_item.op = OP_CLEAR;
            default:     w_item.op = OP_INVALID;
        endcase
    end

    assign o_busy  = (r_fill == 2'd2);
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_q[r_rptr];

    // Two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### hw/rtl/pbf_back.sv
module pbf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  pbf_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_done,
    output logic                              o_deny,
    output logic                              o_result_status,
    output logic [pbf_pkg::ENTRY_COUNT_W-1:0] o_entry_count
);

    import pbf_pkg::*;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_rd_v, n_rd_v;
    logic [ADDR_W-1:0]  r_rd_idx, n_rd_idx;
    logic [ADDR_W-1:0]  r_slot, n_slot;
    logic               r_done, n_done;
    logic               r_deny, n_deny;
    logic               r_status, n_status;
    logic [ENTRY_COUNT_W-1:0] r_out_cnt, n_out_cnt;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [PID_W-1:0]   w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [PID_W-1:0]   w_rdata;

    logic               w_issue;
    logic               w_hit;
    logic               w_scan_end;
    logic               w_room;

    pbf_ram #(
        .WIDTH (PID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Scan status
    assign w_issue    = (r_idx < r_count);
    assign w_hit      = r_rd_v && (w_rdata == r_item.pid);
    assign w_scan_end = w_hit || (!w_issue && !r_rd_v);
    assign w_room     = (r_count < CNT_W'(TABLE_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && ((i_item.op inside {OP_BLOCK, OP_UNBLOCK}) ||
                                (i_item.op == OP_CHECK && i_item.relevant))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = (r_item.op == OP_UNBLOCK && w_hit) ? ST_MOVE_RD : ST_IDLE;
                end
            end
            ST_MOVE_RD: n_state = ST_MOVE_WR;
            ST_MOVE_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath, table access and result
    always_comb begin
        n_item    = r_item;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_v    = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_slot    = r_slot;
        n_done    = 1'b0;
        n_deny    = 1'b0;
        n_status  = STATUS_OK;
        n_out_cnt = ENTRY_COUNT_W'(r_count);
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_count[ADDR_W-1:0];
        w_wdata   = r_item.pid;
        w_raddr   = r_idx[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    case (i_item.op)
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_done    = 1'b1;
                            n_out_cnt = '0;
                        end
                        OP_INVALID: begin
                            n_done   = 1'b1;
                            n_status = STATUS_INVALID;
                        end
                        OP_CHECK: begin
                            // irrelevant kinds never deny and need no search
                            n_done = !i_item.relevant;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    case (r_item.op)
                        OP_CHECK: begin
                            n_done = 1'b1;
                            n_deny = w_hit;
                        end
                        OP_BLOCK: begin
                            n_done = 1'b1;
                            if (!w_hit && w_room) begin
                                w_we      = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_out_cnt = ENTRY_COUNT_W'(r_count + 1'b1);
                            end
                        end
                        default: begin
                            // unblock: on a hit the last entry moves into the slot
                            if (w_hit) begin
                                n_count = r_count - 1'b1;
                                n_slot  = r_rd_idx;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    n_rd_v   = w_issue;
                    n_rd_idx = r_idx[ADDR_W-1:0];
                    if (w_issue) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_MOVE_RD: begin
                w_raddr = r_count[ADDR_W-1:0];
            end
            ST_MOVE_WR: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = w_rdata;
                n_done  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_slot    <= n_slot;
        r_deny    <= n_deny;
        r_status  <= n_status;
        r_out_cnt <= n_out_cnt;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= n_rd_v;
            r_done  <= n_done;
        end
    end

    assign o_done          = r_done;
    assign o_deny          = r_deny;
    assign o_result_status = r_status;
    assign o_entry_count   = r_out_cnt;

endmodule

### hw/rtl/pid_blocklist_filter_top.sv
// Blocklist of process ids with check, block, unblock and unblock-all commands.
// An item is taken when i_start is high and o_busy is low; each item gives one
// result, shown for a single cycle with o_done high, and the receiver cannot
// stall it. Items wait in a two-entry queue, so o_busy rises only when two are
// pending. Timing is set by the linear search through the id table, which has a
// single registered read port: a check of a relevant operation, a block or an
// unblock reads the held entries in order until it hits or reaches the held
// count; a search that hits stops at the hit, and an unblock that hits then
// moves the last entry into the freed slot through a read and a write state.
// Unblock-all, invalid commands and checks of other info changes need no search.
// The table holds at most 256 ids and needs no clearing after reset: only
// entries below the held count are read.
module pid_blocklist_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [pbf_pkg::CMD_W-1:0]         i_command,
    input  logic [pbf_pkg::PID_W-1:0]         i_pid,
    input  logic [pbf_pkg::KIND_W-1:0]        i_operation_kind,
    output logic                              o_done,
    output logic                              o_deny,
    output logic                              o_result_status,
    output logic [pbf_pkg::ENTRY_COUNT_W-1:0] o_entry_count
);

    import pbf_pkg::*;

    t_item w_item;
    logic  w_valid;
    logic  w_pop;

    // Accept and classify
    pbf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_command        (i_command),
        .i_pid            (i_pid),
        .i_operation_kind (i_operation_kind),
        .o_busy           (o_busy),
        .o_valid          (w_valid),
        .o_item           (w_item),
        .i_pop            (w_pop)
    );

    // Table search and update
    pbf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid),
        .i_item          (w_item),
        .o_pop           (w_pop),
        .o_done          (o_done),
        .o_deny          (o_deny),
        .o_result_status (o_result_status),
        .o_entry_count   (o_entry_count)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import pbf_pkg::*;

    // Kinds of a checked access; the never-relevant one comes from the package
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RENAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // Command codes past unblock-all are all invalid
    localparam logic [CMD_W-1:0] CMD_INVALID_LO = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INVALID_HI = 3'd7;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int POOL_MAX    = 512;

    typedef struct packed {
        logic                     deny;
        logic                     status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_verdict;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [CMD_W-1:0]         i_command;
    logic [PID_W-1:0]         i_pid;
    logic [KIND_W-1:0]        i_operation_kind;
    logic                     o_done;
    logic                     o_deny;
    logic                     o_result_status;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;

    // Shadow copy of the blocklist
    logic [PID_W-1:0] held_ids [TABLE_DEPTH];
    int               held_total;

    t_verdict   verdict_q[$];
    t_verdict   seen_want;
    int         failures;
    int         cycles;
    int         items_sent;
    int         denials;
    int         peak_held;
    int         full_refusals;
    int         invalid_hits;
    bit         gaps_on;
    logic [PID_W-1:0] pid_pool [POOL_MAX];

    pid_blocklist_filter_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_command        (i_command),
        .i_pid            (i_pid),
        .i_operation_kind (i_operation_kind),
        .o_done           (o_done),
        .o_deny           (o_deny),
        .o_result_status  (o_result_status),
        .o_entry_count    (o_entry_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Slot of a held id, -1 when absent
    function automatic int find_held(logic [PID_W-1:0] pid);
        for (int i = 0; i < held_total; i++)
            if (held_ids[i] == pid)
                return i;
        return -1;
    endfunction

    // Apply one item to the shadow table and return the result it must give
    function automatic t_verdict apply_item(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                            logic [KIND_W-1:0] kind);
        t_verdict v;
        int       slot;
        v.deny   = 1'b0;
        v.status = STATUS_OK;
        slot     = find_held(pid);
        case (cmd)
            CMD_CHECK: begin
                v.deny = (kind != KIND_OTHER) && (slot >= 0);
            end
            CMD_BLOCK: begin
                if (slot < 0 && held_total < TABLE_DEPTH) begin
                    held_ids[held_total] = pid;
                    held_total++;
                end else if (slot < 0) begin
                    full_refusals++;
                end
            end
            CMD_UNBLOCK: begin
                // swap-remove: last entry fills the hole
                if (slot >= 0) begin
                    held_total--;
                    held_ids[slot] = held_ids[held_total];
                end
            end
            CMD_CLEAR: begin
                held_total = 0;
            end
            default: begin
                v.status = STATUS_INVALID;
                invalid_hits++;
            end
        endcase
        v.entry_count = ENTRY_COUNT_W'(held_total);
        return v;
    endfunction

    // Send one item, wait for it to be taken, then log its expected result
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                             logic [KIND_W-1:0] kind);
        int       gap;
        t_verdict v;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command        = cmd;
        i_pid            = pid;
        i_operation_kind = kind;
        i_start          = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        v = apply_item(cmd, pid, kind);
        verdict_q.push_back(v);
        items_sent++;
        if (v.deny)
            denials++;
        if (held_total > peak_held)
            peak_held = held_total;
    endtask

    // Stop sending and wait for every pending result
    task automatic wait_drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                $error("result with no item pending: deny %0d status %0d count %0d",
                       o_deny, o_result_status, o_entry_count);
                failures++;
            end else begin
                seen_want = verdict_q.pop_front();
                if (o_deny !== seen_want.deny) begin
                    $error("deny: expected %0d, got %0d", seen_want.deny, o_deny);
                    failures++;
                end
                if (o_result_status !== seen_want.status) begin
                    $error("result_status: expected %0d, got %0d",
                           seen_want.status, o_result_status);
                    failures++;
                end
                if (o_entry_count !== seen_want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           seen_want.entry_count, o_entry_count);
                    failures++;
                end
            end
        end
    end

    // Edge ids, every command and kind, and each corner of the table rules
    task automatic test_directed();
        gaps_on = 1'b1;
        send_item(CMD_CHECK,   32'h0000_0000, KIND_WRITE);   // empty table
        send_item(CMD_UNBLOCK, 32'h0000_0000, KIND_WRITE);   // unblock on empty
        send_item(CMD_BLOCK,   32'h0000_0000, KIND_WRITE);
        send_item(CMD_BLOCK,   32'hFFFF_FFFF, KIND_DELETE);
        send_item(CMD_BLOCK,   32'h0000_0000, KIND_RENAME);  // duplicate
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_WRITE);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_RENAME);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_DELETE);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_OTHER);   // never relevant
        send_item(CMD_CHECK,   32'h8000_0000, KIND_WRITE);   // absent id
        send_item(CMD_UNBLOCK, 32'h5555_AAAA, KIND_OTHER);   // unblock absent
        send_item(CMD_BLOCK,   32'hAAAA_5555, KIND_OTHER);
        send_item(CMD_UNBLOCK, 32'h0000_0000, KIND_WRITE);   // first slot, last moves in
        send_item(CMD_CHECK,   32'h0000_0000, KIND_DELETE);
        send_item(CMD_CHECK,   32'hAAAA_5555, KIND_RENAME);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_DELETE);
        for (int c = CMD_INVALID_LO; c <= CMD_INVALID_HI; c++)
            send_item(CMD_W'(c), 32'hFFFF_FFFF, KIND_OTHER);
        send_item(CMD_CLEAR,   32'h1234_5678, KIND_RENAME);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_WRITE);   // gone after clear
        send_item(CMD_CLEAR,   32'h0000_0000, KIND_WRITE);   // clear on empty
        wait_drain();
    endtask

    // Fill to capacity and work at the boundary
    task automatic test_full_table();
        logic [PID_W-1:0] fill_ids [TABLE_DEPTH];
        send_item(CMD_CLEAR, $urandom(), KIND_WRITE);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            // top byte keeps the ids distinct
            fill_ids[i] = {i[7:0], 24'($urandom())};
            send_item(CMD_BLOCK, fill_ids[i], 2'($urandom()));
        end
        gaps_on = 1'b0;
        send_item(CMD_BLOCK,   32'hFFFF_FFFF, KIND_WRITE);   // refused, table full
        send_item(CMD_BLOCK,   fill_ids[17], KIND_WRITE);    // duplicate when full
        send_item(CMD_CHECK,   fill_ids[TABLE_DEPTH-1], KIND_RENAME);
        send_item(CMD_CHECK,   fill_ids[0], KIND_DELETE);
        send_item(CMD_CHECK,   fill_ids[0], KIND_OTHER);
        send_item(CMD_CHECK,   32'hFFFF_FFFF, KIND_WRITE);
        send_item(CMD_UNBLOCK, fill_ids[3], KIND_WRITE);
        send_item(CMD_CHECK,   fill_ids[3], KIND_WRITE);
        send_item(CMD_CHECK,   fill_ids[TABLE_DEPTH-1], KIND_WRITE);
        send_item(CMD_BLOCK,   32'hFFFF_FFFF, KIND_WRITE);   // fits again
        send_item(CMD_UNBLOCK, 32'hFFFF_FFFF, KIND_DELETE);  // last slot
        send_item(CMD_UNBLOCK, fill_ids[TABLE_DEPTH-1], KIND_DELETE);
        send_item(CMD_CHECK,   fill_ids[TABLE_DEPTH-1], KIND_DELETE);
        gaps_on = 1'b1;
        send_item(CMD_CLEAR,   32'h0, KIND_WRITE);
        wait_drain();
    endtask

    // One random item; ids mostly from the first pool_size pool entries
    task automatic random_item(int pool_size, int w_check, int w_block, int w_unblock,
                               int w_clear);
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] pid;
        roll = $urandom_range(0, 99);
        if (roll < w_check)
            cmd = CMD_CHECK;
        else if (roll < w_check + w_block)
            cmd = CMD_BLOCK;
        else if (roll < w_check + w_block + w_unblock)
            cmd = CMD_UNBLOCK;
        else if (roll < w_check + w_block + w_unblock + w_clear)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_W'($urandom_range(CMD_INVALID_LO, CMD_INVALID_HI));
        if ($urandom_range(0, 9) == 0)
            pid = $urandom();
        else
            pid = pid_pool[$urandom_range(0, pool_size - 1)];
        send_item(cmd, pid, 2'($urandom()));
    endtask

    // Random traffic over a small, a medium and a near-full table
    task automatic test_random();
        for (int i = 0; i < POOL_MAX; i++)
            pid_pool[i] = $urandom();
        for (int n = 0; n < 450; n++) begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            random_item(8, 40, 25, 20, 3);
        end
        wait_drain();
        for (int n = 0; n < 500; n++) begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            random_item(64, 40, 35, 15, 1);
        end
        wait_drain();
        // block-heavy phase drives the count high
        for (int n = 0; n < 600; n++) begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            random_item(300, 25, 60, 8, 0);
        end
        wait_drain();
    endtask

    initial begin
        failures         = 0;
        cycles           = 0;
        items_sent       = 0;
        denials          = 0;
        peak_held        = 0;
        full_refusals    = 0;
        invalid_hits     = 0;
        held_total       = 0;
        gaps_on          = 1'b1;
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_command        = CMD_CHECK;
        i_pid            = '0;
        i_operation_kind = KIND_WRITE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random();

        // catch stray results after the last one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items: %0d denied, %0d invalid, peak of %0d held ids,",
                 items_sent, denials, invalid_hits, peak_held);
        $display("and %0d blocks turned away by a full table, in %0d cycles.",
                 full_refusals, cycles);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
